### hw/rtl/clock_set_mode_and_numeral_display_assert.svh
// Assertion macros shared by the clock set-mode RTL.
`ifndef CLOCK_SET_MODE_AND_NUMERAL_DISPLAY_ASSERT_SVH
`define CLOCK_SET_MODE_AND_NUMERAL_DISPLAY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSMND_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in clock set-mode block");

// The consequent must hold in the cycle after the antecedent.
`define CSMND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in clock set-mode block");

`endif

### hw/rtl/csmnd_pkg.sv
`timescale 1ns / 1ps

package csmnd_pkg;

  typedef struct packed {
    logic       rtc_ok;
    logic       button_pressed;
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
  } csmnd_in_t;

  typedef struct packed {
    logic [7:0] seg_byte0;
    logic [7:0] seg_byte1;
    logic [7:0] seg_byte2;
    logic [7:0] seg_byte3;
    logic [7:0] seg_byte4;
    logic       write_back;
    logic [1:0] new_hour_tens;
    logic [3:0] new_hour_units;
    logic [2:0] new_minute_tens;
    logic [3:0] new_minute_units;
    logic [1:0] set_mode;
  } csmnd_out_t;

  typedef struct packed {
    logic blank_hour;
    logic blank_minute;
  } csmnd_blank_t;

  typedef logic [4:0][7:0] csmnd_seg_t;

  localparam logic [1:0] MODE_SHOW   = 2'd0;
  localparam logic [1:0] MODE_HOUR   = 2'd1;
  localparam logic [1:0] MODE_MINUTE = 2'd2;

  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_SHORT = 2'd1;
  localparam logic [1:0] EVT_LONG  = 2'd2;

  localparam logic REG_SHORT_PRESS = 1'b0;
  localparam logic REG_LONG_PRESS  = 1'b1;

  localparam logic [7:0] SHORT_PRESS_RESET = 8'd3;
  localparam logic [7:0] LONG_PRESS_RESET  = 8'd25;

  localparam logic [4:0] CYCLE_LAST = 5'd20;
  localparam logic [4:0] CYCLE_HALF = 5'd10;
  localparam logic [4:0] CYCLE_ZERO = 5'd0;

  localparam csmnd_seg_t ERR_PATTERN_A = {8'hAA, 8'hAA, 8'hA5, 8'h55, 8'h55};
  localparam csmnd_seg_t ERR_PATTERN_B = {8'h55, 8'h55, 8'h5A, 8'hAA, 8'hAA};

  function automatic logic [7:0] units_low(input logic [3:0] u);
    logic [7:0] pat;
    case (u)
      4'd0:    pat = 8'h00;
      4'd1:    pat = 8'h01;
      4'd2:    pat = 8'h03;
      4'd3:    pat = 8'h07;
      4'd4:    pat = 8'h17;
      4'd5:    pat = 8'h37;
      4'd6:    pat = 8'h77;
      4'd7:    pat = 8'h77;
      4'd8:    pat = 8'h77;
      4'd9:    pat = 8'h77;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  function automatic logic [7:0] units_high(input logic [3:0] u);
    logic [7:0] pat;
    case (u)
      4'd7:    pat = 8'h01;
      4'd8:    pat = 8'h03;
      4'd9:    pat = 8'h07;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

### hw/rtl/csmnd_encode.sv
`timescale 1ns / 1ps

module csmnd_encode import csmnd_pkg::*; (
  input  csmnd_in_t    tm,
  input  csmnd_blank_t blank,
  output csmnd_seg_t   seg
);

  logic [7:0] b0, b1, b2, b3, b4;

  always_comb begin
    b0 = units_low(tm.hour_units);
    b1 = units_high(tm.hour_units);
    b3 = units_low(tm.minute_units);
    b4 = units_high(tm.minute_units);
    case (tm.hour_tens)
      2'd2:    b2 = 8'h0C;
      2'd1:    b2 = 8'h08;
      default: b2 = 8'h00;
    endcase
    case (tm.minute_tens)
      3'd5: begin
        b2 = b2 | 8'hD0;
        b4 = b4 | 8'hC0;
      end
      3'd4: begin
        b2 = b2 | 8'hB0;
        b4 = b4 | 8'h80;
      end
      3'd3:    b2 = b2 | 8'hE0;
      3'd2:    b2 = b2 | 8'hC0;
      3'd1:    b2 = b2 | 8'h80;
      default: b2 = b2;
    endcase
    if (blank.blank_hour) begin
      b0 = 8'h00;
      b1 = 8'h00;
      b2 = b2 & 8'hF0;
    end else if (blank.blank_minute) begin
      b2 = b2 & 8'h0F;
      b3 = 8'h00;
      b4 = 8'h00;
    end
  end

  assign seg = {b4, b3, b2, b1, b0};

endmodule

### hw/rtl/clock_set_mode_and_numeral_display.sv
// An accepted item is held in the input register and moves into the output register when the pipeline advances.
// Throughput: one item per cycle; the input and output registers form a two-stage
// pipeline that advances whenever the output is empty or being taken.
// Reset (synchronous, active low) clears the mode, the press, blink and error
// counters and the LED bytes, and loads the press thresholds with 3 and 25.
`timescale 1ns / 1ps

module clock_set_mode_and_numeral_display import csmnd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  csmnd_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output csmnd_out_t out_data
);

`include "clock_set_mode_and_numeral_display_assert.svh"

  logic       s1_valid_r;
  csmnd_in_t  s1_data_r;
  logic       out_valid_r;
  csmnd_out_t out_data_r;

  logic [7:0] short_ticks_r;
  logic [7:0] long_ticks_r;
  logic [7:0] press_r, press_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [4:0] blink_r, blink_nxt;
  logic [4:0] err_r, err_nxt;
  csmnd_seg_t disp_r, disp_nxt;

  logic         adv_out;
  logic         adv_in;
  csmnd_blank_t blank;
  csmnd_seg_t   seg_enc;
  logic [1:0]   evt;
  logic [7:0]   press_inc;
  logic [5:0]   hour_sum;
  logic [5:0]   hour_d;
  logic [6:0]   min_sum;
  logic [6:0]   min_d;
  logic [1:0]   hour_t;
  logic [5:0]   hour_u;
  logic [2:0]   min_t;
  logic [6:0]   min_u;
  csmnd_out_t   res;

  assign adv_out  = s1_valid_r && (!out_valid_r || !out_stall);
  assign adv_in   = in_valid && !in_stall;
  assign in_stall = s1_valid_r && !adv_out;

  assign blank.blank_hour   = (blink_r > CYCLE_HALF) && (mode_r == MODE_HOUR);
  assign blank.blank_minute = (blink_r > CYCLE_HALF) && (mode_r == MODE_MINUTE);

  csmnd_encode u_encode (
    .tm    (s1_data_r),
    .blank (blank),
    .seg   (seg_enc)
  );

  assign press_inc = press_r + 8'd1;

  always_comb begin
    evt = EVT_NONE;
    press_nxt = press_r;
    if (s1_data_r.button_pressed) begin
      if (press_r < long_ticks_r) begin
        press_nxt = press_inc;
        if (press_inc >= long_ticks_r) begin
          evt = EVT_LONG;
        end
      end
    end else begin
      if (press_r >= short_ticks_r && press_r < long_ticks_r) begin
        evt = EVT_SHORT;
      end
      press_nxt = 8'd0;
    end
  end

  always_comb begin
    hour_sum = 6'd1 + {1'b0, s1_data_r.hour_tens, 3'b000}
             + {3'b000, s1_data_r.hour_tens, 1'b0} + {2'b00, s1_data_r.hour_units};
    hour_d = (hour_sum >= 6'd24) ? hour_sum - 6'd24 : hour_sum;
    if (hour_d >= 6'd20) begin
      hour_t = 2'd2;
    end else if (hour_d >= 6'd10) begin
      hour_t = 2'd1;
    end else begin
      hour_t = 2'd0;
    end
    hour_u = hour_d - ({3'b000, hour_t, 1'b0} + {1'b0, hour_t, 3'b000});

    min_sum = 7'd1 + {1'b0, s1_data_r.minute_tens, 3'b000}
            + {3'b000, s1_data_r.minute_tens, 1'b0} + {3'b000, s1_data_r.minute_units};
    min_d = (min_sum >= 7'd60) ? min_sum - 7'd60 : min_sum;
    if (min_d >= 7'd50) begin
      min_t = 3'd5;
    end else if (min_d >= 7'd40) begin
      min_t = 3'd4;
    end else if (min_d >= 7'd30) begin
      min_t = 3'd3;
    end else if (min_d >= 7'd20) begin
      min_t = 3'd2;
    end else if (min_d >= 7'd10) begin
      min_t = 3'd1;
    end else begin
      min_t = 3'd0;
    end
    min_u = min_d - ({3'b000, min_t, 1'b0} + {1'b0, min_t, 3'b000});
  end

  always_comb begin
    mode_nxt  = mode_r;
    blink_nxt = blink_r;
    err_nxt   = err_r;
    disp_nxt  = disp_r;
    res.write_back       = 1'b0;
    res.new_hour_tens    = s1_data_r.hour_tens;
    res.new_hour_units   = s1_data_r.hour_units;
    res.new_minute_tens  = s1_data_r.minute_tens;
    res.new_minute_units = s1_data_r.minute_units;
    if (s1_data_r.rtc_ok) begin
      disp_nxt  = seg_enc;
      blink_nxt = (blink_r == CYCLE_LAST) ? CYCLE_ZERO : blink_r + 5'd1;
      case (mode_r)
        MODE_HOUR: begin
          if (evt == EVT_LONG) begin
            mode_nxt = MODE_MINUTE;
          end else if (evt == EVT_SHORT) begin
            res.new_hour_tens  = hour_t;
            res.new_hour_units = hour_u[3:0];
            res.write_back     = 1'b1;
          end
        end
        MODE_MINUTE: begin
          if (evt == EVT_LONG) begin
            mode_nxt = MODE_SHOW;
          end else if (evt == EVT_SHORT) begin
            res.new_minute_tens  = min_t;
            res.new_minute_units = min_u[3:0];
            res.write_back       = 1'b1;
          end
        end
        default: begin
          if (evt == EVT_LONG) begin
            mode_nxt = MODE_HOUR;
          end
        end
      endcase
    end else begin
      if (err_r == CYCLE_ZERO) begin
        disp_nxt = ERR_PATTERN_A;
      end else if (err_r == CYCLE_HALF) begin
        disp_nxt = ERR_PATTERN_B;
      end
      err_nxt = (err_r == CYCLE_LAST) ? CYCLE_ZERO : err_r + 5'd1;
    end
    res.seg_byte0 = disp_nxt[0];
    res.seg_byte1 = disp_nxt[1];
    res.seg_byte2 = disp_nxt[2];
    res.seg_byte3 = disp_nxt[3];
    res.seg_byte4 = disp_nxt[4];
    res.set_mode  = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      short_ticks_r <= SHORT_PRESS_RESET;
      long_ticks_r  <= LONG_PRESS_RESET;
      press_r       <= 8'd0;
      mode_r        <= MODE_SHOW;
      blink_r       <= CYCLE_ZERO;
      err_r         <= CYCLE_ZERO;
      disp_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SHORT_PRESS: short_ticks_r <= cfg_wdata;
          REG_LONG_PRESS:  long_ticks_r  <= cfg_wdata;
          default:         short_ticks_r <= short_ticks_r;
        endcase
      end
      if (adv_in) begin
        s1_valid_r <= 1'b1;
      end else if (adv_out) begin
        s1_valid_r <= 1'b0;
      end
      if (adv_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (adv_out) begin
        if (s1_data_r.rtc_ok) begin
          press_r <= press_nxt;
        end
        mode_r  <= mode_nxt;
        blink_r <= blink_nxt;
        err_r   <= err_nxt;
        disp_r  <= disp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in) begin
      s1_data_r <= in_data;
    end
    if (adv_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CSMND_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, in_stall, s1_valid_r)
  `CSMND_ASSERT_SAME(a_wb_in_set_mode, clk, rst_n, out_valid_r && out_data_r.write_back,
    out_data_r.set_mode == MODE_HOUR || out_data_r.set_mode == MODE_MINUTE)
  `CSMND_ASSERT_SAME(a_wb_hour_range, clk, rst_n,
    out_valid_r && out_data_r.write_back && out_data_r.set_mode == MODE_HOUR,
    out_data_r.new_hour_units <= 4'd9 &&
    (out_data_r.new_hour_tens < 2'd2 || out_data_r.new_hour_units < 4'd4))
  `CSMND_ASSERT_NEXT(a_counters_in_range, clk, rst_n, 1'b1,
    blink_r <= CYCLE_LAST && err_r <= CYCLE_LAST)

endmodule
